/* rtl/enu_pkg.sv */
package enu_pkg;

    // Unit vectors are signed Q1.30
    localparam int UNIT_W    = 32;
    localparam int FRAC_BITS = 30;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_REF_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REF_Z = 2'd2;

    // Basis derivation sequencer
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOAD  = 7'b0000010,
        ST_NORM  = 7'b0000100,
        ST_SQR   = 7'b0001000,
        ST_ROOT  = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_CROSS = 7'b1000000
    } derive_state_t;

endpackage

/* rtl/ecef_to_local_enu_top.sv */
// ECEF to local east/north/up converter. Write ref_x, ref_y and ref_z (indices 0, 1, 2) on the
// cfg port while the stream is idle; every write restarts a sequencer that rebuilds the Q1.30
// east, north and up unit vectors (up is geocentric), and s_tready stays low until it is done.
// Per vector it steps through load, normalize, squaring, root and divide; then it forms the
// cross product, using a bit-serial square root and a one-bit-per-cycle divider. A polar-axis
// reference ends the sequence at the load step. After that a point beat is taken every cycle
// while m_tready is high or no result is pending; its result passes the input, difference,
// products, sum and round, and saturate/output registers in that order. The whole pipe stalls
// only when m_tready is low with a result pending. A reference on the polar axis (x = y = 0)
// flags degenerate in m_tuser and outputs zero coordinates.
module ecef_to_local_enu_top
    import enu_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // Configuration write port
    input  logic                                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]                      cfg_addr,
    input  logic [COORD_WIDTH-1:0]                    cfg_wdata,
    // Point stream: tdata = {pad, point_z, point_y, point_x}, tlast = last_point
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]        s_tdata,
    input  logic                                      s_tlast,
    // Result stream: tdata = {pad, up, north, east}, tuser = degenerate, tlast = last_result
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]        m_tdata,
    output logic                                      m_tuser,
    output logic                                      m_tlast
);

    localparam int W      = COORD_WIDTH;
    localparam int TD_W   = ((3*W+7)/8)*8;
    localparam int D_W    = W + 1;             // point minus reference
    localparam int PROD_W = D_W + UNIT_W;      // one projection term
    localparam int ACC_W  = PROD_W + 2;        // three terms
    localparam int RND_W  = ACC_W - FRAC_BITS; // after the Q.30 -> Q.0 shift
    // Derivation widths
    localparam int MAG_W   = (W > 31) ? W : 31;
    localparam int SUM_W   = 2*MAG_W + 2;
    localparam int ROOT_W  = MAG_W + 1;
    localparam int R_STEPS = SUM_W / 2;
    localparam int RREM_W  = MAG_W + 4;
    localparam int NUM_W   = MAG_W + FRAC_BITS + 1;
    localparam int DREM_W  = MAG_W + 2;
    localparam int Q_W     = FRAC_BITS + 1;
    localparam int CNT_W   = $clog2(R_STEPS + 1);

    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [63:0]      X_HALF   = 64'(1) <<< (FRAC_BITS - 1);

    // ------------------------------------------------------------------
    // Reference registers and derived basis
    // ------------------------------------------------------------------
    logic signed [W-1:0]      ref_reg [3];
    logic signed [UNIT_W-1:0] east_u_reg [3];
    logic signed [UNIT_W-1:0] north_u_reg [3];
    logic signed [UNIT_W-1:0] up_u_reg [3];
    logic                     degen_reg;

    derive_state_t            state_reg;
    logic                     vec_sel_reg;   // 0: east, 1: up
    logic [1:0]               comp_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [MAG_W-1:0]         mag_reg [3];
    logic                     neg_reg [3];
    logic [2*MAG_W-1:0]       sq_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [RREM_W-1:0]        rrem_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [DREM_W-1:0]        drem_reg;
    logic [Q_W-1:0]           nlow_reg;
    logic [Q_W-1:0]           q_reg;
    logic signed [63:0]       xprod_reg;
    logic signed [63:0]       xacc_reg;

    // raw vector for the current unitize pass
    logic signed [D_W-1:0]    raw_v [3];
    logic [MAG_W-1:0]         raw_mag [3];
    logic [MAG_W-1:0]         big;
    logic [MAG_W-1:0]         big01;

    always_comb begin
        raw_v[0] = vec_sel_reg ? D_W'(ref_reg[0]) : -D_W'(ref_reg[1]);
        raw_v[1] = vec_sel_reg ? D_W'(ref_reg[1]) : D_W'(ref_reg[0]);
        raw_v[2] = vec_sel_reg ? D_W'(ref_reg[2]) : '0;
        for (int i = 0; i < 3; i++) begin
            raw_mag[i] = MAG_W'($unsigned(raw_v[i][D_W-1] ? -raw_v[i] : raw_v[i]));
        end
        big01 = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
        big   = (big01 > mag_reg[2]) ? big01 : mag_reg[2];
    end

    // square root step
    logic [RREM_W-1:0] rrem_cat;
    logic [RREM_W-1:0] r_trial;
    logic              r_ge;
    // divide step
    logic [DREM_W-1:0] d_cat;
    logic [DREM_W-1:0] d_div;
    logic              d_ge;
    logic [Q_W-1:0]    q_next;
    logic [NUM_W-1:0]  num;
    logic [UNIT_W-1:0] unit_next;
    // cross product step
    logic signed [UNIT_W-1:0] xa;
    logic signed [UNIT_W-1:0] xb;
    logic [2:0]               xj;
    logic signed [63:0]       xdiff;
    logic signed [63:0]       xrnd;

    always_comb begin
        rrem_cat  = {rrem_reg[RREM_W-3:0], sum_reg[SUM_W-1 -: 2]};
        r_trial   = RREM_W'({root_reg, 2'b01});
        r_ge      = rrem_cat >= r_trial;

        d_cat     = {drem_reg[DREM_W-2:0], nlow_reg[Q_W-1]};
        d_div     = DREM_W'(root_reg);
        d_ge      = d_cat >= d_div;
        q_next    = {q_reg[Q_W-2:0], d_ge};
        unit_next = neg_reg[comp_reg] ? -UNIT_W'(q_next) : UNIT_W'(q_next);

        num = NUM_W'({mag_reg[comp_reg], {FRAC_BITS{1'b0}}}) + NUM_W'(root_reg >> 1);

        case (cnt_reg[2:0])
            3'd0: begin xa = up_u_reg[1]; xb = east_u_reg[2]; end
            3'd1: begin xa = up_u_reg[2]; xb = east_u_reg[1]; end
            3'd2: begin xa = up_u_reg[2]; xb = east_u_reg[0]; end
            3'd3: begin xa = up_u_reg[0]; xb = east_u_reg[2]; end
            3'd4: begin xa = up_u_reg[0]; xb = east_u_reg[1]; end
            3'd5: begin xa = up_u_reg[1]; xb = east_u_reg[0]; end
            default: begin xa = '0; xb = '0; end
        endcase
        xj    = cnt_reg[2:0] - 3'd1;
        xdiff = xacc_reg - xprod_reg;
        xrnd  = (xdiff + X_HALF) >>> FRAC_BITS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            degen_reg   <= 1'b1;
            vec_sel_reg <= 1'b0;
            comp_reg    <= '0;
            cnt_reg     <= '0;
            for (int i = 0; i < 3; i++) ref_reg[i] <= '0;
        end else if (cfg_wr_en && (cfg_addr == REG_REF_X || cfg_addr == REG_REF_Y ||
                                   cfg_addr == REG_REF_Z)) begin
            // every write rebuilds the basis from scratch
            ref_reg[cfg_addr] <= cfg_wdata;
            state_reg         <= ST_LOAD;
            vec_sel_reg       <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                end
                ST_LOAD: begin
                    if (!vec_sel_reg && ref_reg[0] == '0 && ref_reg[1] == '0) begin
                        degen_reg <= 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            east_u_reg[i]  <= '0;
                            north_u_reg[i] <= '0;
                            up_u_reg[i]    <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end else begin
                        degen_reg <= 1'b0;
                        for (int i = 0; i < 3; i++) begin
                            mag_reg[i] <= raw_mag[i];
                            neg_reg[i] <= raw_v[i][D_W-1];
                        end
                        state_reg <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    // scale up until the largest magnitude reaches 2^30
                    if ((big >> FRAC_BITS) == '0) begin
                        for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 1;
                    end else begin
                        cnt_reg   <= '0;
                        sum_reg   <= '0;
                        state_reg <= ST_SQR;
                    end
                end
                ST_SQR: begin
                    if (cnt_reg < CNT_W'(3)) begin
                        sq_reg <= (2*MAG_W)'(mag_reg[cnt_reg[1:0]]) *
                                  (2*MAG_W)'(mag_reg[cnt_reg[1:0]]);
                    end
                    if (cnt_reg != '0) sum_reg <= sum_reg + SUM_W'(sq_reg);
                    if (cnt_reg == CNT_W'(3)) begin
                        cnt_reg   <= '0;
                        rrem_reg  <= '0;
                        root_reg  <= '0;
                        state_reg <= ST_ROOT;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_ROOT: begin
                    // two radicand bits per cycle
                    sum_reg  <= sum_reg << 2;
                    rrem_reg <= r_ge ? rrem_cat - r_trial : rrem_cat;
                    root_reg <= {root_reg[ROOT_W-2:0], r_ge};
                    if (cnt_reg == CNT_W'(R_STEPS - 1)) begin
                        cnt_reg   <= '0;
                        comp_reg  <= '0;
                        state_reg <= ST_DIV;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DIV: begin
                    if (cnt_reg == '0) begin
                        drem_reg <= DREM_W'(num >> Q_W);
                        nlow_reg <= num[Q_W-1:0];
                        q_reg    <= '0;
                        cnt_reg  <= cnt_reg + 1'b1;
                    end else begin
                        drem_reg <= d_ge ? d_cat - d_div : d_cat;
                        nlow_reg <= nlow_reg << 1;
                        q_reg    <= q_next;
                        if (cnt_reg == CNT_W'(Q_W)) begin
                            if (vec_sel_reg) up_u_reg[comp_reg] <= unit_next;
                            else east_u_reg[comp_reg] <= unit_next;
                            cnt_reg <= '0;
                            if (comp_reg == 2'd2) begin
                                if (vec_sel_reg) begin
                                    state_reg <= ST_CROSS;
                                end else begin
                                    vec_sel_reg <= 1'b1;
                                    state_reg   <= ST_LOAD;
                                end
                            end else begin
                                comp_reg <= comp_reg + 1'b1;
                            end
                        end else begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                ST_CROSS: begin
                    // north = up x east, one product per cycle
                    xprod_reg <= 64'(xa) * 64'(xb);
                    if (cnt_reg != '0) begin
                        if (!xj[0]) xacc_reg <= xprod_reg;
                        else north_u_reg[xj[2:1]] <= xrnd[UNIT_W-1:0];
                    end
                    if (cnt_reg == CNT_W'(6)) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Projection pipeline: in -> diff -> products -> sum/round -> out
    // ------------------------------------------------------------------
    logic advance;
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance && (state_reg == ST_IDLE);

    logic                    in_v_reg, d_v_reg, p_v_reg, r_v_reg;
    logic                    in_last_reg, d_last_reg, p_last_reg, r_last_reg;
    logic signed [W-1:0]     pt_reg [3];
    logic signed [D_W-1:0]   d_reg [3];
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic signed [RND_W-1:0] rnd_reg [3];
    logic [W-1:0]            out_reg [3];
    logic                    m_tvalid_reg, m_tlast_reg, m_tuser_reg;

    logic signed [ACC_W-1:0] acc [3];
    logic signed [ACC_W-1:0] acc_rnd [3];
    logic [W-1:0]            sat [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            acc[k]     = ACC_W'(prod_reg[k][0]) + ACC_W'(prod_reg[k][1]) +
                         ACC_W'(prod_reg[k][2]);
            acc_rnd[k] = (acc[k] + HALF_LSB) >>> FRAC_BITS;
            // in range when the bits above the sign all match it
            if (rnd_reg[k][RND_W-1:W-1] == '0 || rnd_reg[k][RND_W-1:W-1] == '1) begin
                sat[k] = rnd_reg[k][W-1:0];
            end else if (rnd_reg[k][RND_W-1]) begin
                sat[k] = {1'b1, {(W-1){1'b0}}};
            end else begin
                sat[k] = {1'b0, {(W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg     <= 1'b0;
            d_v_reg      <= 1'b0;
            p_v_reg      <= 1'b0;
            r_v_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            in_v_reg     <= s_tvalid && s_tready;
            d_v_reg      <= in_v_reg;
            p_v_reg      <= d_v_reg;
            r_v_reg      <= p_v_reg;
            m_tvalid_reg <= r_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i < 3; i++) pt_reg[i] <= s_tdata[i*W +: W];
            in_last_reg <= s_tlast;

            for (int i = 0; i < 3; i++) d_reg[i] <= D_W'(pt_reg[i]) - D_W'(ref_reg[i]);
            d_last_reg <= in_last_reg;

            for (int i = 0; i < 3; i++) begin
                prod_reg[0][i] <= PROD_W'(d_reg[i]) * PROD_W'(east_u_reg[i]);
                prod_reg[1][i] <= PROD_W'(d_reg[i]) * PROD_W'(north_u_reg[i]);
                prod_reg[2][i] <= PROD_W'(d_reg[i]) * PROD_W'(up_u_reg[i]);
            end
            p_last_reg <= d_last_reg;

            for (int k = 0; k < 3; k++) rnd_reg[k] <= acc_rnd[k][RND_W-1:0];
            r_last_reg <= p_last_reg;

            for (int k = 0; k < 3; k++) out_reg[k] <= degen_reg ? '0 : sat[k];
            m_tuser_reg <= degen_reg;
            m_tlast_reg <= r_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = TD_W'({out_reg[2], out_reg[1], out_reg[0]});

endmodule
